// ===== design/pwg_pkg.sv =====
// Package for the periodic waveform generator.
// Holds shared widths, mode and register codes, controller types and the sine table function.
// Depends on nothing.
package pwg_pkg;

    // Field and register widths.
    localparam int PERIOD_W      = 12;
    localparam int SAMPLE_W      = 12;
    localparam int MODE_W        = 2;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 12;
    localparam int POSITION_BITS = 12;

    // Reset values of the configuration registers.
    localparam logic [MODE_W-1:0]   WAVE_MODE_RESET = 2'd0;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 12'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN      = 12'd2;

    // Waveform select codes; the unused code plays as square.
    localparam logic [MODE_W-1:0] MODE_SINE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAW    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_WAVE_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD    = 1'd1;

    // Sine table geometry.
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_SHIFT       = SINE_IDX_W + 1;
    localparam int SAW_SHIFT        = SAMPLE_W;

    // Output codes.
    localparam logic [SAMPLE_W-1:0] SINE_OFFSET = 12'd2048;
    localparam logic [SAMPLE_W-1:0] SQUARE_HIGH = 12'd4095;
    localparam logic [SAMPLE_W-1:0] SQUARE_LOW  = 12'd0;

    // Divider geometry: the quotient never exceeds 2048, so twelve steps suffice.
    localparam int DIV_STEPS = 12;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int REM_W     = PERIOD_W + 1;
    localparam int NUM_W     = PERIOD_W + SAW_SHIFT + 1;

    // Fixed-point constants of the table builder.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] HALF_Q30    = 64'd536870912;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } pwg_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;
        logic step;
        logic load_out;
    } pwg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_last;
    } pwg_status_t;

    // One sine table entry: round(1024 * sin(2*pi*i/depth)), from a quarter-wave
    // Taylor series in Q2.30 with truncated products. Evaluated at elaboration.
    function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned i);
        logic [63:0] n;
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] rr;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos_sum;
        logic [63:0] neg_sum;
        logic [63:0] s;
        logic [63:0] mag;
        n    = 64'(i) * 64'd4;
        quad = n / SINE_TABLE_DEPTH;
        r    = n % SINE_TABLE_DEPTH;
        rr   = quad[0] ? (64'(SINE_TABLE_DEPTH) - r) : r;
        x    = (HALF_PI_Q30 * rr) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        pos_sum = x;
        neg_sum = 64'd0;
        for (int k = 1; k <= 8; k++) begin
            term = (term * x2) >> 30;
            // Each term divides by (2k)(2k+1) for its step of the series.
            unique case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                default: term = term / 64'd272;
            endcase
            if (k % 2 == 1) begin
                neg_sum = neg_sum + term;
            end else begin
                pos_sum = pos_sum + term;
            end
        end
        s   = (pos_sum > neg_sum) ? (pos_sum - neg_sum) : 64'd0;
        mag = (s * 64'd1024 + HALF_Q30) >> 30;
        if (quad >= 64'd2) begin
            return SAMPLE_W'(-$signed(mag));
        end
        return SAMPLE_W'(mag);
    endfunction

endpackage

// ===== design/periodic_waveform_generator.sv =====
// Top level of the periodic waveform generator: configuration registers and
// the controller and datapath instances. Depends on pwg_pkg, pwg_ctrl, pwg_datapath.
//
// Each input transfer is one sample tick and yields exactly one result transfer
// carrying a 12-bit DAC code and a flag on the last sample of the period. An item
// passes from acceptance to a loaded result through the accept, twelve steps of
// the shared restoring divider that forms round(pos*N/period), and the table lookup
// and output load, which waits while the output register is full. The next item is
// accepted while a finished result still waits in the output register. Write
// wave_mode and period_samples only while the block is idle.
module periodic_waveform_generator
    import pwg_pkg::*;
#(
    parameter int POSITION_BITS = pwg_pkg::POSITION_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_restart,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SAMPLE_W-1:0]    m_sample,
    output logic                   m_period_end
);

    logic [MODE_W-1:0]   wave_mode_reg;
    logic [PERIOD_W-1:0] period_reg;
    pwg_cmd_t            cmd;
    pwg_status_t         status;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_mode_reg <= WAVE_MODE_RESET;
            period_reg    <= PERIOD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_WAVE_MODE: wave_mode_reg <= cfg_wdata[MODE_W-1:0];
                CFG_PERIOD:    period_reg    <= cfg_wdata[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pwg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pwg_datapath #(
        .POSITION_BITS (POSITION_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .wave_mode      (wave_mode_reg),
        .period_samples (period_reg),
        .s_restart      (s_restart),
        .m_sample       (m_sample),
        .m_period_end   (m_period_end)
    );

endmodule

// ===== design/pwg_ctrl.sv =====
// Controller state machine of the periodic waveform generator.
// Sequences the accept, the divider steps and the output register load.
// Depends on pwg_pkg.
module pwg_ctrl
    import pwg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  pwg_status_t status,
    output pwg_cmd_t    cmd
);

    pwg_state_t state_reg;
    pwg_state_t state_next;
    logic       m_valid_reg;
    logic       m_valid_next;

    // State and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // The result moves to the output register once it is free.
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output valid holds until the transfer completes.
    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

`ifndef ASSERT_OFF
    a_start_enters_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> (state_reg == ST_DIV))
        else $error("start did not enter the divide state");
    a_finish_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && m_valid_reg && !m_ready) |=> (state_reg == ST_FINISH))
        else $error("finished result left while the output register was full");
    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid_reg)
        else $error("output load did not raise valid");
`endif

endmodule

// ===== design/pwg_datapath.sv =====
// Datapath of the periodic waveform generator: position counter, shared
// restoring divider, sine table and output payload registers.
// Depends on pwg_pkg.
module pwg_datapath
    import pwg_pkg::*;
#(
    parameter int POSITION_BITS = pwg_pkg::POSITION_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pwg_cmd_t            cmd,
    output pwg_status_t         status,
    input  logic [MODE_W-1:0]   wave_mode,
    input  logic [PERIOD_W-1:0] period_samples,
    input  logic                s_restart,
    output logic [SAMPLE_W-1:0] m_sample,
    output logic                m_period_end
);

    localparam int CW = (POSITION_BITS > PERIOD_W) ? POSITION_BITS : PERIOD_W;

    logic [POSITION_BITS-1:0] pos_reg;
    logic [POSITION_BITS-1:0] pos_next;
    logic [PERIOD_W-1:0]      cur_pos_reg;
    logic [PERIOD_W-1:0]      per_reg;
    logic [MODE_W-1:0]        mode_reg;
    logic                     end_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [REM_W-1:0]         rem_next;
    logic [DIV_STEPS-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0]     cnt_reg;
    logic [SAMPLE_W-1:0]      sample_reg;
    logic                     period_end_reg;

    logic [PERIOD_W-1:0] p_eff;
    logic [CW-1:0]       pos_ext;
    logic [CW-1:0]       p_ext;
    logic [CW-1:0]       pos_clamp;
    logic                end_now;
    logic [PERIOD_W-1:0] pos_short;
    logic [NUM_W-1:0]    numer;
    logic [REM_W-1:0]    divisor;
    logic [REM_W:0]      trial;
    logic                trial_ge;
    logic [SAMPLE_W-1:0] sample_calc;

    logic signed [SAMPLE_W-1:0] sine_rom [SINE_TABLE_DEPTH];

    // Constant sine table, built at elaboration.
    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
        assign sine_rom[g] = sine_entry(g);
    end

    // Position of this tick after restart, short-period and stale-position handling.
    always_comb begin
        p_eff     = (period_samples < PERIOD_MIN) ? PERIOD_MIN : period_samples;
        pos_ext   = CW'(pos_reg);
        p_ext     = CW'(p_eff);
        pos_clamp = (s_restart || pos_ext >= p_ext) ? '0 : pos_ext;
        end_now   = (pos_clamp == p_ext - CW'(1));
        pos_next  = end_now ? '0 : POSITION_BITS'(pos_clamp + CW'(1));
        pos_short = pos_clamp[PERIOD_W-1:0];
        if (wave_mode == MODE_SINE) begin
            numer = (NUM_W'(pos_short) << SINE_SHIFT) + NUM_W'(p_eff);
        end else begin
            numer = (NUM_W'(pos_short) << SAW_SHIFT) + NUM_W'(p_eff);
        end
    end

    // One restoring divide step against twice the period.
    always_comb begin
        divisor  = {per_reg, 1'b0};
        trial    = {rem_reg, quo_reg[DIV_STEPS-1]};
        trial_ge = (trial >= {1'b0, divisor});
        rem_next = trial_ge ? REM_W'(trial - {1'b0, divisor}) : trial[REM_W-1:0];
    end

    assign status.div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    // Sample selection from the quotient or the position.
    always_comb begin
        unique case (mode_reg)
            MODE_SINE: begin
                sample_calc = SINE_OFFSET + SAMPLE_W'(sine_rom[quo_reg[SINE_IDX_W-1:0]]);
            end
            MODE_SAW: begin
                sample_calc = quo_reg[SAMPLE_W-1:0];
            end
            default: begin
                sample_calc = (cur_pos_reg < (per_reg >> 1)) ? SQUARE_HIGH : SQUARE_LOW;
            end
        endcase
    end

    // Position counter state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (cmd.start) begin
            pos_reg <= pos_next;
        end
    end

    // Divider and per-item registers.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            cur_pos_reg <= pos_short;
            per_reg     <= p_eff;
            mode_reg    <= wave_mode;
            end_reg     <= end_now;
            rem_reg     <= numer[NUM_W-1:DIV_STEPS];
            quo_reg     <= numer[DIV_STEPS-1:0];
            cnt_reg     <= '0;
        end else if (cmd.step) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_STEPS-2:0], trial_ge};
            cnt_reg <= cnt_reg + DIV_CNT_W'(1);
        end
    end

    // Output payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            sample_reg     <= sample_calc;
            period_end_reg <= end_reg;
        end
    end

    assign m_sample     = sample_reg;
    assign m_period_end = period_end_reg;

`ifndef ASSERT_OFF
    a_rem_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (rem_reg < {per_reg, 1'b0}))
        else $error("divider remainder out of range");
    a_pos_in_period: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> (cur_pos_reg < per_reg))
        else $error("position not inside the period");
`endif

endmodule

// ===== tb/tb_periodic_waveform_generator.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the periodic waveform generator: predicts the DAC code
// and period flag of every sample tick and checks each result transfer in order.
// Depends on pwg_pkg and periodic_waveform_generator.
module tb_periodic_waveform_generator;
    import pwg_pkg::*;

    localparam int CLK_PERIOD_NS = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int REPORT_LIMIT  = 10;

    // The fourth mode code is not named in the package; it must play as square.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Fixed-point constants for building the expected sine table.
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint unsigned ROUND_HALF_Q30   = 64'd536870912;

    typedef struct packed {
        logic [SAMPLE_W-1:0] code;
        logic                last;
    } dac_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_restart;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [SAMPLE_W-1:0]    m_sample;
    logic                   m_period_end;

    // Shadow of the block's configuration and period position.
    logic [MODE_W-1:0]        tone_mode;
    logic [PERIOD_W-1:0]      tone_period;
    logic [POSITION_BITS-1:0] tone_position;
    int                       sine_lut [SINE_TABLE_DEPTH];

    dac_result_t pending_samples[$];
    int          mismatches         = 0;
    int          quiet_cycles       = 0;
    int          sender_idle_pct    = 0;
    int          receiver_stall_pct = 0;

    periodic_waveform_generator u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_restart    (s_restart),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample     (m_sample),
        .m_period_end (m_period_end)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD_NS / 2) aclk = ~aclk;
    end

    // Signed table entry: quarter-wave Taylor series in Q2.30, mirrored into all
    // four quadrants and scaled to an amplitude of 1024 with rounding.
    function automatic int sine_lut_entry(input int unsigned i);
        longint unsigned depth;
        longint unsigned quadrant;
        longint unsigned offset;
        longint unsigned angle;
        longint unsigned angle_sq;
        longint unsigned term;
        longint unsigned plus_sum;
        longint unsigned minus_sum;
        longint unsigned divisor;
        longint unsigned sine_q30;
        longint unsigned magnitude;
        depth    = SINE_TABLE_DEPTH;
        quadrant = (4 * i) / depth;
        offset   = (4 * i) % depth;
        if (quadrant % 2 == 1) begin
            offset = depth - offset;
        end
        angle     = (QUARTER_TURN_Q30 * offset) / depth;
        angle_sq  = (angle * angle) >> 30;
        term      = angle;
        plus_sum  = angle;
        minus_sum = 0;
        for (int k = 1; k <= 8; k++) begin
            divisor = (2 * k) * (2 * k + 1);
            term    = ((term * angle_sq) >> 30) / divisor;
            if (k % 2 == 1) begin
                minus_sum += term;
            end else begin
                plus_sum += term;
            end
        end
        sine_q30  = (plus_sum > minus_sum) ? (plus_sum - minus_sum) : 0;
        magnitude = (sine_q30 * 1024 + ROUND_HALF_Q30) >> 30;
        return (quadrant >= 2) ? -int'(magnitude) : int'(magnitude);
    endfunction

    // Work out the DAC code and period flag of one accepted tick and step the position.
    task automatic advance_tone_model(input logic restart);
        int unsigned period;
        int unsigned pos;
        int unsigned lut_idx;
        dac_result_t want;
        period = (tone_period < 2) ? 2 : tone_period;
        pos    = restart ? 0 : tone_position;
        // A position left over from a longer period counts as the start of a new one.
        if (pos >= period) begin
            pos = 0;
        end
        case (tone_mode)
            MODE_SINE: begin
                lut_idx   = (pos * 2 * SINE_TABLE_DEPTH + period) / (2 * period);
                lut_idx   = lut_idx % SINE_TABLE_DEPTH;
                want.code = SAMPLE_W'(2048 + sine_lut[lut_idx]);
            end
            MODE_SAW: begin
                want.code = SAMPLE_W'((4096 * pos + period) / (2 * period));
            end
            default: begin
                want.code = (pos < period / 2) ? 12'd4095 : 12'd0;
            end
        endcase
        want.last     = (pos == period - 1);
        tone_position = want.last ? '0 : POSITION_BITS'(pos + 1);
        pending_samples.push_back(want);
    endtask

    task automatic note_mismatch(input dac_result_t want, input logic orphan);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            if (orphan) begin
                $display("%0t: result with nothing pending: sample %0d end %0b",
                         $realtime, m_sample, m_period_end);
            end else begin
                $display("%0t: mismatch: expected sample %0d end %0b, got sample %0d end %0b",
                         $realtime, want.code, want.last, m_sample, m_period_end);
            end
        end
    endtask

    // Result side: check each transfer against the oldest prediction and draw
    // the next ready value.
    always @(posedge aclk) begin : result_check
        dac_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_samples.size() == 0) begin
                note_mismatch('0, 1'b1);
            end else begin
                want = pending_samples.pop_front();
                if (want.code !== m_sample || want.last !== m_period_end) begin
                    note_mismatch(want, 1'b0);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Watchdog: too long without any transfer on either channel ends the run.
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one tick after an optional random gap and wait for its transfer.
    task automatic send_tick(input logic restart);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_restart <= restart;
        do @(posedge aclk); while (!s_ready);
        advance_tone_model(restart);
    endtask

    // Hold off new ticks until every predicted result is back and the block is quiet.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge aclk);
        if (index == CFG_WAVE_MODE) begin
            tone_mode = data[MODE_W-1:0];
        end else begin
            tone_period = data;
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // Sine at the reset period of 100 samples, starting with a restart.
    task automatic test_reset_defaults();
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);
    endtask

    // Periods of 0 and 1 behave as 2; a flag on every other tick.
    task automatic test_short_periods();
        wait_for_drain();
        write_reg(CFG_WAVE_MODE, CFG_DATA_W'(MODE_SAW));
        write_reg(CFG_PERIOD, 12'd0);
        repeat (3) send_tick(1'b0);
        wait_for_drain();
        write_reg(CFG_PERIOD, 12'd1);
        write_reg(CFG_WAVE_MODE, CFG_DATA_W'(MODE_SQUARE));
        repeat (3) send_tick(1'b0);
    endtask

    // The unused mode code plays as square.
    task automatic test_unused_mode();
        wait_for_drain();
        write_reg(CFG_WAVE_MODE, CFG_DATA_W'(MODE_UNUSED));
        write_reg(CFG_PERIOD, 12'd5);
        send_tick(1'b1);
        repeat (2) send_tick(1'b0);
    endtask

    // Longest period in sine and sawtooth.
    task automatic test_period_extremes();
        wait_for_drain();
        write_reg(CFG_WAVE_MODE, CFG_DATA_W'(MODE_SINE));
        write_reg(CFG_PERIOD, 12'd4095);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_for_drain();
        write_reg(CFG_WAVE_MODE, CFG_DATA_W'(MODE_SAW));
        repeat (2) send_tick(1'b0);
    endtask

    // Lowering the period below the current position restarts the period,
    // and a restart in mid-period goes back to position zero.
    task automatic test_stale_position();
        wait_for_drain();
        write_reg(CFG_PERIOD, 12'd9);
        send_tick(1'b1);
        repeat (4) send_tick(1'b0);
        wait_for_drain();
        write_reg(CFG_PERIOD, 12'd3);
        repeat (2) send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // Random segments: each picks a mode and a period (mostly short, at times
    // an extreme), then sends a run of ticks with occasional restarts.
    task automatic test_random_ticks(input int idle_pct, input int stall_pct,
                                     input int tick_count);
        int sent;
        int run_len;
        logic [PERIOD_W-1:0] period_pick;
        sent = 0;
        while (sent < tick_count) begin
            wait_for_drain();
            sender_idle_pct    = idle_pct;
            receiver_stall_pct = stall_pct;
            write_reg(CFG_WAVE_MODE, CFG_DATA_W'($urandom_range(3)));
            case ($urandom_range(9))
                0:       period_pick = PERIOD_W'($urandom_range(2));
                1:       period_pick = 12'hFFF;
                2:       period_pick = PERIOD_W'($urandom_range(4095));
                default: period_pick = PERIOD_W'($urandom_range(2, 48));
            endcase
            write_reg(CFG_PERIOD, period_pick);
            run_len = $urandom_range(15, 40);
            for (int i = 0; i < run_len && sent < tick_count; i++) begin
                send_tick($urandom_range(19) == 0);
                sent++;
            end
        end
    endtask

    // Reset, directed cases, then random traffic under each idling pattern.
    initial begin : stimulus
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            sine_lut[i] = sine_lut_entry(i);
        end
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_WAVE_MODE;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_restart     = 1'b0;
        tone_mode     = MODE_SINE;
        tone_period   = 12'd100;
        tone_position = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_short_periods();
        test_unused_mode();
        test_period_extremes();
        test_stale_position();

        test_random_ticks(0, 0, 110);
        test_random_ticks(86, 0, 110);
        test_random_ticks(0, 86, 110);
        test_random_ticks(35, 35, 110);

        wait_for_drain();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
